[sv/six_bit_text_encoder_macros.svh]
// Assertion macros used by the encoder top level.
`ifndef SIX_BIT_TEXT_ENCODER_MACROS_SVH
`define SIX_BIT_TEXT_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SBTE_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("encoder check failed");

// Next-cycle implication, disabled while reset is held.
`define SBTE_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("encoder check failed");

`endif

[sv/sbte_pkg.sv]
// Types and constants for the six-bit text encoder.
`timescale 1ns / 1ps
package sbte_pkg;

    localparam logic [6:0] LINE_FEED   = 7'd10;
    localparam logic [6:0] CHAR_OFFSET = 7'h20;
    localparam logic [6:0] CHAR_MAX    = 7'h5f;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // One group of up to three bytes, zero padded, low byte in the low bits,
    // and whether a line feed follows its four characters.
    typedef struct packed {
        logic [23:0] bits;
        logic        lf;
    } t_group;

endpackage

[sv/sbte_front.sv]
// Front end: gathers bytes into groups and tracks the line position.
`timescale 1ns / 1ps
module sbte_front
    import sbte_pkg::*;
#(
    parameter int CHARS_PER_LINE = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [7:0]   i_data,
    input  logic         i_last,
    input  logic         i_queue_full,
    output logic         o_ready,
    output logic         o_push,
    output t_group       o_group
);

    localparam int LINE_W = $clog2(CHARS_PER_LINE + 4);

    logic [7:0]        r_held0, n_held0;
    logic [7:0]        r_held1, n_held1;
    logic [1:0]        r_count, n_count;
    logic [LINE_W-1:0] r_line,  n_line;

    logic              w_accept;
    logic              w_hold;
    logic [LINE_W-1:0] w_sum;
    logic [7:0]        w_b0, w_b1, w_b2;

    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;
    assign w_hold   = (r_count < 2'd2) && !i_last;
    assign w_sum    = r_line + LINE_W'(4);

    always_comb begin
        // missing bytes of a partial group read as zero
        w_b0 = (r_count == 2'd0) ? i_data : r_held0;
        w_b1 = (r_count == 2'd0) ? 8'd0 : ((r_count == 2'd1) ? i_data : r_held1);
        w_b2 = (r_count == 2'd2) ? i_data : 8'd0;

        o_group.bits = {w_b2, w_b1, w_b0};
        o_group.lf   = (w_sum >= LINE_W'(CHARS_PER_LINE));
        o_push       = w_accept && !w_hold;

        n_held0 = r_held0;
        n_held1 = r_held1;
        n_count = r_count;
        n_line  = r_line;
        if (w_accept) begin
            if (w_hold) begin
                if (r_count[0]) begin
                    n_held1 = i_data;
                end else begin
                    n_held0 = i_data;
                end
                n_count = r_count + 2'd1;
            end else begin
                n_count = 2'd0;
                n_line  = (o_group.lf || i_last) ? '0 : w_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_line  <= '0;
        end else begin
            r_count <= n_count;
            r_line  <= n_line;
        end
        r_held0 <= n_held0;
        r_held1 <= n_held1;
    end

endmodule

[sv/sbte_queue.sv]
// Short queue of complete groups between front and back end.
`timescale 1ns / 1ps
module sbte_queue
    import sbte_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_group,
    input  logic   i_pop,
    output t_group o_head,
    output logic   o_full,
    output logic   o_empty
);

    t_group                 r_entry [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_fill,   n_fill;

    assign o_full  = (r_fill == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_fill   = r_fill;
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_group;
        end
    end

endmodule

[sv/sbte_back.sv]
// Back end: emits the four characters of a group and the optional line feed.
`timescale 1ns / 1ps
module sbte_back
    import sbte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_group     i_head,
    input  logic       i_empty,
    input  logic       i_ready,
    output logic       o_pop,
    output logic       o_valid,
    output logic [6:0] o_char,
    output logic       o_last
);

    logic [2:0] r_idx, n_idx;
    logic [5:0] w_sextet;
    logic       w_accept;

    assign o_valid  = !i_empty;
    assign w_accept = o_valid && i_ready;

    always_comb begin
        case (r_idx)
            3'd0:    w_sextet = i_head.bits[5:0];
            3'd1:    w_sextet = i_head.bits[11:6];
            3'd2:    w_sextet = i_head.bits[17:12];
            default: w_sextet = i_head.bits[23:18];
        endcase

        o_char = (r_idx == 3'd4) ? LINE_FEED : ({1'b0, w_sextet} + CHAR_OFFSET);
        o_last = ((r_idx == 3'd3) && !i_head.lf) || (r_idx == 3'd4);
        o_pop  = w_accept && o_last;

        n_idx = r_idx;
        if (w_accept) begin
            n_idx = o_last ? 3'd0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

[sv/six_bit_text_encoder.sv]
// A group-completing byte is written into the four-entry group queue; its first
// character shows once that group is at the queue head. Characters leave one per
// cycle while the receiver is ready, 4 or 5 per group on the single output port.
// Bytes, held or group-completing, enter one per cycle while the queue has room.
// Reset (synchronous, active low) clears the group and line counters, the queue
// and the character index.
`timescale 1ns / 1ps
`include "six_bit_text_encoder_macros.svh"
module six_bit_text_encoder
    import sbte_pkg::*;
#(
    parameter int CHARS_PER_LINE = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // block_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic       m_axis_tlast    // run_last
);

    t_group     w_group;
    t_group     w_head;
    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_empty;
    logic [6:0] w_char;

    sbte_front #(
        .CHARS_PER_LINE(CHARS_PER_LINE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_data       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_queue_full (w_full),
        .o_ready      (s_axis_tready),
        .o_push       (w_push),
        .o_group      (w_group)
    );

    sbte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_group (w_group),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    sbte_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .i_ready (m_axis_tready),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .o_char  (w_char),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_char};

    // a group may only enter a queue with room
    `SBTE_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, w_push, !w_full)
    // a line feed always closes the characters of its group
    `SBTE_ASSERT_NOW(a_lf_is_last, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tdata[6:0] == LINE_FEED), m_axis_tlast)
    // characters stay in the printable range
    `SBTE_ASSERT_NOW(a_char_range, i_clk, i_rst_n, m_axis_tvalid,
        (w_char == LINE_FEED) || ((w_char >= CHAR_OFFSET) && (w_char <= CHAR_MAX)))
    // a queued group with nothing taken keeps the output valid
    `SBTE_ASSERT_NEXT(a_queue_holds, i_clk, i_rst_n,
        m_axis_tvalid && !w_pop, m_axis_tvalid)

endmodule

[tb/tb.sv]
// Self-checking stream testbench for the six-bit text encoder.
`timescale 1ns / 1ps
module tb;
    import sbte_pkg::*;

    localparam int LINE_LEN   = 64;
    localparam int CALM_TAIL  = 40;
    localparam int HALF_CYCLE = 5;
    localparam int N_ITEMS    = 380;

    typedef struct {
        logic [7:0] data;
        logic       blk_end;
        logic       hold;     // wait for every outstanding character first
    } t_byte_item;

    typedef struct {
        logic [6:0] ch;
        logic       last;
    } t_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;    // [7:0] data_byte
    logic       s_axis_tlast = 1'b0;  // block_end
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;         // [6:0] out_char, [7] zero
    logic       m_axis_tlast;         // run_last

    t_byte_item byte_q[$];
    t_char      char_q[$];

    // encoder state mirrored by the predictor
    logic [7:0] held [2];
    int         n_held;
    int         line_chars;

    int   n_errors = 0;
    int   tx_gap = 0;
    int   rx_gap = 0;
    logic hold_armed = 1'b0;
    logic drained = 1'b1;
    logic calm = 1'b0;

    six_bit_text_encoder #(
        .CHARS_PER_LINE(LINE_LEN)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #HALF_CYCLE i_clk = ~i_clk;

    function automatic void encode_byte(input logic [7:0] b, input logic blk_end);
        logic [7:0]  b0, b1, b2;
        logic [23:0] grp;
        logic        lf;
        t_char       c;
        if (n_held < 2 && !blk_end) begin
            held[n_held & 1] = b;
            n_held++;
            return;
        end
        b0 = (n_held == 0) ? b : held[0];
        b1 = (n_held == 1) ? b : ((n_held == 2) ? held[1] : 8'h00);
        b2 = (n_held == 2) ? b : 8'h00;
        grp = {b2, b1, b0};
        line_chars += 4;
        lf = (line_chars >= LINE_LEN);
        for (int k = 0; k < 4; k++) begin
            c.ch   = {1'b0, grp[6*k +: 6]} + CHAR_OFFSET;
            c.last = (k == 3) && !lf;
            char_q.push_back(c);
        end
        if (lf) begin
            line_chars = 0;
            c.ch   = LINE_FEED;
            c.last = 1'b1;
            char_q.push_back(c);
        end
        n_held  = 0;
        held[0] = '0;
        held[1] = '0;
        if (blk_end)
            line_chars = 0;
    endfunction

    function automatic void add_byte(input logic [7:0] d, input logic e,
                                     input logic h = 1'b0);
        t_byte_item it;
        it.data    = d;
        it.blk_end = e;
        it.hold    = h;
        byte_q.push_back(it);
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_byte_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap        <= 0;
            hold_armed    <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (tx_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                tx_gap        <= tx_gap - 1;
            end else if (byte_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (byte_q[0].hold && !hold_armed) begin
                // one empty slot so that drained reflects the last transaction
                s_axis_tvalid <= 1'b0;
                hold_armed    <= 1'b1;
            end else if (byte_q[0].hold && !drained) begin
                s_axis_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                s_axis_tvalid <= 1'b0;
                tx_gap        <= $urandom_range(0, 10);
            end else begin
                it = byte_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= it.data;
                s_axis_tlast  <= it.blk_end;
                hold_armed    <= 1'b0;
            end
        end
        calm <= (byte_q.size() < CALM_TAIL);
    end

    // monitor: predicts on input transactions, checks output transactions
    always @(posedge i_clk) begin
        t_char want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_gap        <= 0;
            drained       <= 1'b1;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                encode_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                if (char_q.size() == 0) begin
                    $error("unexpected character 0x%02h", m_axis_tdata);
                    n_errors++;
                end else begin
                    want = char_q.pop_front();
                    if (m_axis_tdata[6:0] !== want.ch) begin
                        $error("out_char: expected 0x%02h, got 0x%02h",
                               want.ch, m_axis_tdata[6:0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[7] !== 1'b0) begin
                        $error("tdata pad bit: expected 0, got %b", m_axis_tdata[7]);
                        n_errors++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("run_last: expected %b, got %b", want.last, m_axis_tlast);
                        n_errors++;
                    end
                end
            end
            drained <= (char_q.size() == 0);
            if (rx_gap != 0) begin
                m_axis_tready <= 1'b0;
                rx_gap        <= rx_gap - 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                rx_gap        <= $urandom_range(0, 10);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int blk_len;
        int n_items;
        logic [7:0] d;
        n_held     = 0;
        line_chars = 0;
        held[0]    = '0;
        held[1]    = '0;

        // full groups at the byte extremes
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hff, 1'b0);
        add_byte(8'hff, 1'b0);
        add_byte(8'hff, 1'b0);
        // block end on a lone byte, then on two bytes (zero padding)
        add_byte(8'ha5, 1'b1);
        add_byte(8'h3c, 1'b0);
        add_byte(8'hc3, 1'b1);
        // full group, then a partial one closed by block end
        add_byte(8'h55, 1'b0);
        add_byte(8'haa, 1'b0);
        add_byte(8'h0f, 1'b0);
        add_byte(8'hf0, 1'b1);
        // block end that completes a group
        add_byte(8'h12, 1'b0);
        add_byte(8'h34, 1'b0);
        add_byte(8'h56, 1'b1);
        // sender waits for the output to drain
        add_byte(8'h80, 1'b0, 1'b1);
        add_byte(8'h01, 1'b0);
        add_byte(8'h7f, 1'b0);
        add_byte(8'hfe, 1'b1);

        // random blocks: long ones cross line boundaries, short ones hit block end
        n_items = byte_q.size();
        while (n_items < N_ITEMS) begin
            if ($urandom_range(0, 9) < 4)
                blk_len = $urandom_range(50, 150);
            else
                blk_len = $urandom_range(1, 12);
            if (blk_len > N_ITEMS - n_items)
                blk_len = N_ITEMS - n_items;
            for (int k = 0; k < blk_len; k++) begin
                case ($urandom_range(0, 9))
                    0:       d = 8'h00;
                    1:       d = 8'hff;
                    default: d = 8'($urandom_range(0, 255));
                endcase
                add_byte(d, k == blk_len - 1, (k == 0) && ($urandom_range(0, 5) == 0));
            end
            n_items += blk_len;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (byte_q.size() != 0 || s_axis_tvalid) @(negedge i_clk);
        while (char_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        if (char_q.size() != 0) begin
            $error("%0d expected characters never arrived", char_q.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/sbte_pkg.sv
sv/sbte_front.sv
sv/sbte_queue.sv
sv/sbte_back.sv
sv/six_bit_text_encoder.sv
tb/tb.sv
